FILE: design/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Operation and status codes, controller states and the control/status bundles.
// No dependencies.
package dq_pkg;

  localparam int VALUE_W  = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_REAR  = 2'd1,
    OP_DEL_FRONT = 2'd2,
    OP_DEL_REAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOAD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

FILE: design/dq_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Used for the queue entry storage. No dependencies.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: design/dq_ctrl.sv
// Controller state machine for the double-ended queue.
// Sequences capture, pointer update, entry read and result load. Uses dq_pkg.
module dq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dq_pkg::sts_t  sts,
  output dq_pkg::cmd_t  cmd
);
  import dq_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_READ;
      S_READ: state_next = S_LOAD;
      S_LOAD: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.capture  = in_valid && (state == S_IDLE);
    cmd.exec     = (state == S_EXEC);
    cmd.read     = (state == S_READ);
    cmd.load_out = (state == S_LOAD) && sts.out_free;
  end

`ifndef SYNTHESIS
  a_load_needs_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded while output register busy");
  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.exec)
    else $error("captured item not executed next cycle");
  a_exec_then_read: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> cmd.read)
    else $error("entry read did not follow pointer update");
`endif

endmodule

FILE: design/dq_datapath.sv
// Datapath for the double-ended queue: pointers, count, entry RAM and result register.
// Driven by dq_ctrl through cmd_t; uses dq_pkg and dq_ram.
module dq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dq_pkg::cmd_t                    cmd,
  output dq_pkg::sts_t                    sts,
  input  logic [dq_pkg::OP_W-1:0]         operation,
  input  logic signed [dq_pkg::VALUE_W-1:0] value_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dq_pkg::STATUS_W-1:0]     status,
  output logic signed [dq_pkg::VALUE_W-1:0] front_value,
  output logic signed [dq_pkg::VALUE_W-1:0] rear_value,
  output logic                            is_empty,
  output logic [dq_pkg::OCC_W-1:0]        occupancy
);
  import dq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == AW'(DEPTH - 1)) ? '0 : AW'(i + 1'b1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    ring_prev = (i == '0) ? AW'(DEPTH - 1) : AW'(i - 1'b1);
  endfunction

  op_t                op_q;
  logic [VALUE_W-1:0] value_q;
  logic [AW-1:0]      head, head_next;
  logic [AW-1:0]      tail, tail_next;
  logic [CW-1:0]      count, count_next;
  status_t            status_q, status_next;
  logic               full, empty;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] rdata_a, rdata_b;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign sts.out_free = !out_valid || out_ready;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op_t'(operation);
      value_q <= value_in;
    end
  end

  // Apply the operation: unless rejected, move one pointer and, for an insert, write one entry
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    status_next = status_q;
    we          = 1'b0;
    waddr       = tail;
    if (cmd.exec) begin
      status_next = ST_OK;
      case (op_q)
        OP_INS_FRONT: begin
          if (full) begin
            status_next = ST_OVER;
          end else begin
            head_next  = ring_prev(head);
            waddr      = ring_prev(head);
            we         = 1'b1;
            count_next = CW'(count + 1'b1);
          end
        end
        OP_INS_REAR: begin
          if (full) begin
            status_next = ST_OVER;
          end else begin
            tail_next  = ring_next(tail);
            waddr      = tail;
            we         = 1'b1;
            count_next = CW'(count + 1'b1);
          end
        end
        OP_DEL_FRONT: begin
          if (empty) begin
            status_next = ST_UNDER;
          end else begin
            head_next  = ring_next(head);
            count_next = CW'(count - 1'b1);
          end
        end
        OP_DEL_REAR: begin
          if (empty) begin
            status_next = ST_UNDER;
          end else begin
            tail_next  = ring_prev(tail);
            count_next = CW'(count - 1'b1);
          end
        end
        default: status_next = ST_OK;
      endcase
    end
  end

  // Queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    status_q <= status_next;
  end

  // Entry storage: read front and rear after the pointer update
  dq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (value_q),
    .re      (cmd.read),
    .raddr_a (head),
    .raddr_b (ring_prev(tail)),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= status_q;
      front_value <= empty ? '0 : $signed(rdata_a);
      rear_value  <= empty ? '0 : $signed(rdata_b);
      is_empty    <= empty;
      occupancy   <= OCC_W'(count);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");
  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    ((tail >= head) ? (int'(tail) - int'(head)) : (int'(tail) + DEPTH - int'(head)))
      == (full ? 0 : int'(count)))
    else $error("head, tail and count disagree");
  a_reject_holds_state: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && status_next != ST_OK) |=> ($stable(count) && $stable(head) && $stable(tail)))
    else $error("rejected operation changed queue state");
`endif

endmodule

FILE: design/double_ended_queue.sv
// Top level of the double-ended queue: controller plus datapath.
// Uses dq_pkg, dq_ctrl and dq_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------------
//   in      | in_valid / in_ready  | operation, value_in
//   out     | out_valid/out_ready  | status, front_value, rear_value, is_empty, occupancy
//
// After its input transfer an item passes through pointer update with entry write,
// registered RAM read of front and rear, and result load; the load waits while the
// output register is busy. A new item is taken only once the previous one is loaded.
// The result register holds a finished result while the next item is taken and worked.
// Reset empties the queue at once; entries are not cleared.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dq_pkg::OP_W-1:0]           operation,
  input  logic signed [dq_pkg::VALUE_W-1:0] value_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dq_pkg::STATUS_W-1:0]       status,
  output logic signed [dq_pkg::VALUE_W-1:0] front_value,
  output logic signed [dq_pkg::VALUE_W-1:0] rear_value,
  output logic                              is_empty,
  output logic [dq_pkg::OCC_W-1:0]          occupancy
);
  import dq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .operation   (operation),
    .value_in    (value_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .front_value (front_value),
    .rear_value  (rear_value),
    .is_empty    (is_empty),
    .occupancy   (occupancy)
  );

endmodule
